### hdl/sbfd_pkg.sv
// ----------------------------------------------------------------------------
// sbfd_pkg
// Shared types and constants of the sync byte frame deframer: store sizing,
// frame ids, event codes, record status codes and the record structure.
// ----------------------------------------------------------------------------
package sbfd_pkg;

	localparam int STORE_DEPTH = 512;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	localparam int MAX_RESULTS = 64;
	localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Sync, id, length and checksum bytes around the payload.
	localparam int FRAME_OVERHEAD = 4;

	localparam logic [7:0] SYNC_RESET = 8'hAA;

	localparam logic [7:0] ID_FAULT       = 8'h10;
	localparam logic [7:0] ID_POWER_GOOD  = 8'h11;
	localparam logic [7:0] ID_KILL_SWITCH = 8'h12;
	localparam logic [7:0] ID_CURRENTS    = 8'h13;

	localparam logic [7:0] CODE_FAULT      = 8'h01;
	localparam logic [7:0] CODE_POWER_GOOD = 8'h02;

	localparam logic [7:0] LEN_EVENT       = 8'd2;
	localparam logic [7:0] LEN_KILL_SWITCH = 8'd0;
	localparam logic [7:0] LEN_CURRENTS    = 8'd32;

	localparam logic [2:0] ST_OK             = 3'd0;
	localparam logic [2:0] ST_CHECKSUM_ERR   = 3'd1;
	localparam logic [2:0] ST_BAD_FAULT      = 3'd2;
	localparam logic [2:0] ST_BAD_POWER_GOOD = 3'd3;
	localparam logic [2:0] ST_BAD_KILL       = 3'd4;
	localparam logic [2:0] ST_BAD_CURRENTS   = 3'd5;
	localparam logic [2:0] ST_UNKNOWN_ID     = 3'd6;

	typedef struct packed {
		logic [7:0] msg_id;
		logic [7:0] payload_len;
		logic [2:0] status;
		logic       has_channel;
		logic [7:0] channel;
		logic [7:0] event_code;
		logic [7:0] checksum_received;
		logic [7:0] checksum_expected;
		logic       last_of_run;
	} rec_t;

endpackage

### hdl/sync_byte_frame_deframer.sv
// ----------------------------------------------------------------------------
// sync_byte_frame_deframer
// Finds sync/id/length/payload/XOR-checksum frames in a received byte stream
// and gives one classified record per checked frame.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes come in on rx_byte with rx_valid; a request is taken at a
// clock edge where rx_valid is high and rx_stall is low. A four-entry queue
// takes bytes while the frame engine works, and rx_stall rises when it fills.
// Records leave on res_valid with one port per field; a request is taken when
// res_valid is high and res_stall is low. last_of_run marks the final record
// caused by one byte. While res_stall is high the record holds and the engine
// stops at its next record until the output register frees.
// The sync byte is written through cfg_valid/cfg_ready/sync_byte. The user must
// write it only while the block is idle; the block itself does not enforce this.
// cfg_ready is always high. A byte that leaves fewer than four bytes in the store
// goes from idle through the top state to the finish state. Otherwise the engine
// also reads the store, one byte at a time over its single read port: it searches
// for sync, reads the header, then the payload and checksum, builds the record
// and starts the next pass. A record appears on the output in the cycle after it
// is released.
// Reset clears the store, the queue and the output, and sets sync to 0xAA.
// ----------------------------------------------------------------------------
module sync_byte_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] sync_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] msg_id,
	output logic [7:0] payload_len,
	output logic [2:0] status,
	output logic       has_channel,
	output logic [7:0] channel,
	output logic [7:0] event_code,
	output logic [7:0] checksum_received,
	output logic [7:0] checksum_expected,
	output logic       last_of_run
);

	logic           q_valid;
	logic [7:0]     q_byte;
	logic           q_pop;
	logic [7:0]     sync_val;
	logic           snd_valid;
	logic           snd_ready;
	sbfd_pkg::rec_t snd_rec;
	sbfd_pkg::rec_t rec;

	sbfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_byte   (rx_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.sync_byte (sync_byte),
		.q_valid   (q_valid),
		.q_byte    (q_byte),
		.q_pop     (q_pop),
		.sync_val  (sync_val)
	);

	sbfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_byte    (q_byte),
		.q_pop     (q_pop),
		.sync_val  (sync_val),
		.snd_valid (snd_valid),
		.snd_rec   (snd_rec),
		.snd_ready (snd_ready)
	);

	sbfd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.snd_valid (snd_valid),
		.snd_rec   (snd_rec),
		.snd_ready (snd_ready),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.rec       (rec)
	);

	assign msg_id            = rec.msg_id;
	assign payload_len       = rec.payload_len;
	assign status            = rec.status;
	assign has_channel       = rec.has_channel;
	assign channel           = rec.channel;
	assign event_code        = rec.event_code;
	assign checksum_received = rec.checksum_received;
	assign checksum_expected = rec.checksum_expected;
	assign last_of_run       = rec.last_of_run;

endmodule

### hdl/sbfd_front.sv
// ----------------------------------------------------------------------------
// sbfd_front
// Input side: accepts received bytes into a short queue toward the frame
// engine and holds the sync byte register.
// ----------------------------------------------------------------------------
module sbfd_front (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] sync_byte,
	output logic       q_valid,
	output logic [7:0] q_byte,
	input  logic       q_pop,
	output logic [7:0] sync_val
);

	logic [7:0]                     fifo_q [sbfd_pkg::QUEUE_DEPTH];
	logic [sbfd_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [sbfd_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [sbfd_pkg::QCNT_W-1:0]    cnt_q;
	logic [7:0]                     sync_q;
	logic                           push;

	function automatic logic [sbfd_pkg::QPTR_W-1:0] ptr_inc(
		logic [sbfd_pkg::QPTR_W-1:0] p);
		if (p == sbfd_pkg::QPTR_W'(sbfd_pkg::QUEUE_DEPTH - 1))
			return '0;
		return p + sbfd_pkg::QPTR_W'(1);
	endfunction

	assign rx_stall  = (cnt_q == sbfd_pkg::QCNT_W'(sbfd_pkg::QUEUE_DEPTH));
	assign push      = rx_valid && !rx_stall;
	assign q_valid   = (cnt_q != '0);
	assign q_byte    = fifo_q[rd_ptr_q];
	assign cfg_ready = 1'b1;
	assign sync_val  = sync_q;

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			sync_q   <= sbfd_pkg::SYNC_RESET;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (q_pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !q_pop)
				cnt_q <= cnt_q + sbfd_pkg::QCNT_W'(1);
			else if (!push && q_pop)
				cnt_q <= cnt_q - sbfd_pkg::QCNT_W'(1);
			if (cfg_valid && cfg_ready)
				sync_q <= sync_byte;
		end
	end

endmodule

### hdl/sbfd_back.sv
// ----------------------------------------------------------------------------
// sbfd_back
// Frame engine: appends each byte to the circular byte store, then walks the
// store through its single read port to find sync, header, payload and
// checksum, and builds one record per checked frame.
// ----------------------------------------------------------------------------
module sbfd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  logic [7:0]          q_byte,
	output logic                q_pop,
	input  logic [7:0]          sync_val,
	output logic                snd_valid,
	output sbfd_pkg::rec_t      snd_rec,
	input  logic                snd_ready
);

	localparam int AW = sbfd_pkg::ADDR_W;
	localparam int CW = sbfd_pkg::CNT_W;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_TOP   = 4'd1;
	localparam logic [3:0] S_SC_RD = 4'd2;
	localparam logic [3:0] S_SC_CK = 4'd3;
	localparam logic [3:0] S_ID_RD = 4'd4;
	localparam logic [3:0] S_ID_CK = 4'd5;
	localparam logic [3:0] S_LN_RD = 4'd6;
	localparam logic [3:0] S_LN_CK = 4'd7;
	localparam logic [3:0] S_PL_RD = 4'd8;
	localparam logic [3:0] S_PL_CK = 4'd9;
	localparam logic [3:0] S_CLS   = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;

	logic [3:0]                    state_q;
	logic [AW-1:0]                 head_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 idx_q;
	logic [sbfd_pkg::NRES_W-1:0]   nres_q;
	logic                          pend_valid_q;
	sbfd_pkg::rec_t                pend_q;

	logic [7:0]    mem_q [sbfd_pkg::STORE_DEPTH];
	logic [7:0]    rdata_q;
	logic [7:0]    id_q;
	logic [7:0]    len_q;
	logic [7:0]    xor_q;
	logic [7:0]    ch_q;
	logic [7:0]    code_q;
	logic [7:0]    rx_q;

	logic [CW-1:0] off;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic          store_full;
	logic [CW-1:0] remain;
	logic [CW-1:0] hdr_full;
	logic [CW-1:0] frame_full;
	logic [CW-1:0] dropn;
	logic          csum_bad;
	logic          cls_go;
	logic [2:0]    st;
	logic          hc;
	sbfd_pkg::rec_t new_rec;

	function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] n);
		logic [CW:0] sum;
		sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, n};
		if (sum >= (CW + 1)'(sbfd_pkg::STORE_DEPTH))
			sum = sum - (CW + 1)'(sbfd_pkg::STORE_DEPTH);
		return sum[AW-1:0];
	endfunction

	always_comb begin
		case (state_q)
			S_SC_RD: off = idx_q;
			S_ID_RD: off = CW'(1);
			S_LN_RD: off = CW'(2);
			default: off = idx_q + CW'(3);
		endcase
	end

	assign raddr      = wrap_add(head_q, off);
	assign store_full = (count_q == CW'(sbfd_pkg::STORE_DEPTH));
	// When the store is full the oldest byte is overwritten in place.
	assign waddr      = store_full ? head_q : wrap_add(head_q, count_q);
	assign q_pop      = (state_q == S_IDLE) && q_valid;
	assign remain     = count_q - idx_q;
	assign hdr_full   = CW'(sbfd_pkg::FRAME_OVERHEAD) + CW'(rdata_q);
	assign frame_full = CW'(sbfd_pkg::FRAME_OVERHEAD) + CW'(len_q);
	assign csum_bad   = (xor_q != rx_q);
	assign dropn      = csum_bad ? CW'(1) : frame_full;
	assign cls_go     = !pend_valid_q || snd_ready;

	always_comb begin
		st = sbfd_pkg::ST_UNKNOWN_ID;
		hc = 1'b0;
		if (csum_bad) begin
			st = sbfd_pkg::ST_CHECKSUM_ERR;
		end else begin
			unique case (id_q)
				sbfd_pkg::ID_FAULT: begin
					hc = (len_q == sbfd_pkg::LEN_EVENT) && (code_q == sbfd_pkg::CODE_FAULT);
					st = hc ? sbfd_pkg::ST_OK : sbfd_pkg::ST_BAD_FAULT;
				end
				sbfd_pkg::ID_POWER_GOOD: begin
					hc = (len_q == sbfd_pkg::LEN_EVENT) &&
					     (code_q == sbfd_pkg::CODE_POWER_GOOD);
					st = hc ? sbfd_pkg::ST_OK : sbfd_pkg::ST_BAD_POWER_GOOD;
				end
				sbfd_pkg::ID_KILL_SWITCH: begin
					st = (len_q == sbfd_pkg::LEN_KILL_SWITCH) ? sbfd_pkg::ST_OK
					                                          : sbfd_pkg::ST_BAD_KILL;
				end
				sbfd_pkg::ID_CURRENTS: begin
					st = (len_q == sbfd_pkg::LEN_CURRENTS) ? sbfd_pkg::ST_OK
					                                       : sbfd_pkg::ST_BAD_CURRENTS;
				end
				default: st = sbfd_pkg::ST_UNKNOWN_ID;
			endcase
		end
		new_rec.msg_id            = id_q;
		new_rec.payload_len       = len_q;
		new_rec.status            = st;
		new_rec.has_channel       = hc;
		new_rec.channel           = hc ? ch_q : 8'd0;
		new_rec.event_code        = hc ? code_q : 8'd0;
		new_rec.checksum_received = rx_q;
		new_rec.checksum_expected = xor_q;
		new_rec.last_of_run       = 1'b0;
	end

	// The newest record is held back until it is known whether another one
	// follows for the same byte, so that the last one can be marked.
	always_comb begin
		snd_valid = 1'b0;
		snd_rec   = pend_q;
		if (state_q == S_CLS) begin
			snd_valid           = pend_valid_q;
			snd_rec.last_of_run = 1'b0;
		end else if (state_q == S_FIN) begin
			snd_valid           = pend_valid_q;
			snd_rec.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			mem_q[waddr] <= q_byte;
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_ID_CK: id_q <= rdata_q;
			S_LN_CK: begin
				len_q <= rdata_q;
				xor_q <= id_q ^ rdata_q;
			end
			S_PL_CK: begin
				if (idx_q == CW'(len_q)) begin
					rx_q <= rdata_q;
				end else begin
					xor_q <= xor_q ^ rdata_q;
					if (idx_q == CW'(0))
						ch_q <= rdata_q;
					if (idx_q == CW'(1))
						code_q <= rdata_q;
				end
			end
			S_CLS: begin
				if (cls_go)
					pend_q <= new_rec;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			nres_q       <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (store_full)
							head_q <= wrap_add(head_q, CW'(1));
						else
							count_q <= count_q + CW'(1);
						nres_q  <= '0;
						state_q <= S_TOP;
					end
				end
				S_TOP: begin
					if (nres_q == sbfd_pkg::NRES_W'(sbfd_pkg::MAX_RESULTS) ||
					    count_q < CW'(sbfd_pkg::FRAME_OVERHEAD)) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= '0;
						state_q <= S_SC_RD;
					end
				end
				S_SC_RD: state_q <= S_SC_CK;
				S_SC_CK: begin
					if (rdata_q == sync_val) begin
						head_q  <= wrap_add(head_q, idx_q);
						count_q <= remain;
						if (remain < CW'(sbfd_pkg::FRAME_OVERHEAD))
							state_q <= S_FIN;
						else
							state_q <= S_ID_RD;
					end else if (idx_q + CW'(1) == count_q) begin
						// No sync byte anywhere in the store.
						head_q  <= '0;
						count_q <= '0;
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SC_RD;
					end
				end
				S_ID_RD: state_q <= S_ID_CK;
				S_ID_CK: state_q <= S_LN_RD;
				S_LN_RD: state_q <= S_LN_CK;
				S_LN_CK: begin
					if (count_q < hdr_full) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= '0;
						state_q <= S_PL_RD;
					end
				end
				S_PL_RD: state_q <= S_PL_CK;
				S_PL_CK: begin
					if (idx_q == CW'(len_q)) begin
						state_q <= S_CLS;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_PL_RD;
					end
				end
				S_CLS: begin
					if (cls_go) begin
						pend_valid_q <= 1'b1;
						nres_q       <= nres_q + sbfd_pkg::NRES_W'(1);
						if (dropn >= count_q) begin
							head_q  <= '0;
							count_q <= '0;
						end else begin
							head_q  <= wrap_add(head_q, dropn);
							count_q <= count_q - dropn;
						end
						state_q <= S_TOP;
					end
				end
				S_FIN: begin
					if (cls_go) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hdl/sbfd_out.sv
// ----------------------------------------------------------------------------
// sbfd_out
// Output register: holds one finished record for the receiver so that the
// frame engine can go on while the receiver stalls.
// ----------------------------------------------------------------------------
module sbfd_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           snd_valid,
	input  sbfd_pkg::rec_t snd_rec,
	output logic           snd_ready,
	output logic           res_valid,
	input  logic           res_stall,
	output sbfd_pkg::rec_t rec
);

	logic           valid_q;
	sbfd_pkg::rec_t rec_q;
	logic           load;

	assign snd_ready = !valid_q || !res_stall;
	assign load      = snd_valid && snd_ready;
	assign res_valid = valid_q;
	assign rec       = rec_q;

	always_ff @(posedge clk) begin
		if (load)
			rec_q <= snd_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule

### sim/sync_byte_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// sync_byte_frame_deframer_tb
// Self-checking bench for the sync byte frame deframer. Received bytes are
// sent as framed messages, broken frames and line noise. A scoreboard
// re-parses the byte stream on its own and compares every record field by
// field, in order. Both sides idle and stall at random, and the sync byte
// is moved between phases, including its extreme values.
// ----------------------------------------------------------------------------
module sync_byte_frame_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sbfd_pkg::*;

	// The block works through at most four queued bytes, each of which may
	// walk a full-length frame, so this covers any work left after the last
	// record.
	localparam int SETTLE_CYCLES  = 3000;
	localparam int BYTES_PER_PHASE = 8;

	class record_ledger;
		logic [7:0] sync;
		logic [7:0] held_bytes[$];
		rec_t due[$];
		int unsigned failures;

		function new();
			sync = SYNC_RESET;
			failures = 0;
		endfunction

		function void discard(int n);
			if (n >= held_bytes.size())
				held_bytes.delete();
			else
				held_bytes = held_bytes[n:$];
		endfunction

		// Store the byte and parse as many records as it completes.
		function void take_byte(logic [7:0] b);
			int n, k, full, i;
			logic [7:0] id, len, rx, sum, ch, code, want;
			logic [2:0] st;
			logic hc;
			n = 0;
			if (held_bytes.size() >= STORE_DEPTH)
				void'(held_bytes.pop_front());
			held_bytes.push_back(b);
			while (n < MAX_RESULTS) begin
				if (held_bytes.size() < FRAME_OVERHEAD)
					break;
				k = 0;
				while (k < held_bytes.size() && held_bytes[k] != sync)
					k++;
				if (k == held_bytes.size()) begin
					held_bytes.delete();
					break;
				end
				discard(k);
				if (held_bytes.size() < FRAME_OVERHEAD)
					break;
				id = held_bytes[1];
				len = held_bytes[2];
				full = FRAME_OVERHEAD + len;
				if (held_bytes.size() < full)
					break;
				sum = id ^ len;
				for (i = 0; i < len; i++)
					sum ^= held_bytes[3 + i];
				rx = held_bytes[3 + len];
				hc = 1'b0;
				ch = 8'h00;
				code = 8'h00;
				if (rx != sum) begin
					// Only the sync byte goes; what follows is searched again.
					st = ST_CHECKSUM_ERR;
					discard(1);
				end else begin
					case (id)
						ID_FAULT, ID_POWER_GOOD: begin
							want = (id == ID_FAULT) ? CODE_FAULT : CODE_POWER_GOOD;
							st = (id == ID_FAULT) ? ST_BAD_FAULT : ST_BAD_POWER_GOOD;
							if (len == LEN_EVENT && held_bytes[4] == want) begin
								st = ST_OK;
								hc = 1'b1;
								ch = held_bytes[3];
								code = held_bytes[4];
							end
						end
						ID_KILL_SWITCH: st = (len == LEN_KILL_SWITCH) ? ST_OK : ST_BAD_KILL;
						ID_CURRENTS: st = (len == LEN_CURRENTS) ? ST_OK : ST_BAD_CURRENTS;
						default: st = ST_UNKNOWN_ID;
					endcase
					discard(full);
				end
				due.push_back('{id, len, st, hc, ch, code, rx, sum, 1'b0});
				n++;
			end
			if (n > 0)
				due[due.size() - 1].last_of_run = 1'b1;
		endfunction

		function void match_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				failures++;
			end
		endfunction

		function void check_record(rec_t got);
			rec_t want;
			if (due.size() == 0) begin
				$error("record with msg_id %0h arrived with none pending", got.msg_id);
				failures++;
				return;
			end
			want = due.pop_front();
			match_field("msg_id", want.msg_id, got.msg_id);
			match_field("payload_len", want.payload_len, got.payload_len);
			match_field("status", 8'(want.status), 8'(got.status));
			match_field("has_channel", 8'(want.has_channel), 8'(got.has_channel));
			match_field("channel", want.channel, got.channel);
			match_field("event_code", want.event_code, got.event_code);
			match_field("checksum_received", want.checksum_received,
				got.checksum_received);
			match_field("checksum_expected", want.checksum_expected,
				got.checksum_expected);
			match_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b1;
	logic       rx_valid = 1'b0;
	logic       rx_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_sync = SYNC_RESET;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] msg_id;
	logic [7:0] payload_len;
	logic [2:0] status;
	logic       has_channel;
	logic [7:0] channel;
	logic [7:0] event_code;
	logic [7:0] checksum_received;
	logic [7:0] checksum_expected;
	logic       last_of_run;

	record_ledger ledger;
	logic [7:0] outgoing[$];
	logic [7:0] cur_sync = SYNC_RESET;
	bit rx_quiet = 1'b0;
	bit res_quiet = 1'b0;
	int stall_left = 0;
	int phase_sync_pick;

	sync_byte_frame_deframer uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.sync_byte(cfg_sync),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.msg_id(msg_id),
		.payload_len(payload_len),
		.status(status),
		.has_channel(has_channel),
		.channel(channel),
		.event_code(event_code),
		.checksum_received(checksum_received),
		.checksum_expected(checksum_expected),
		.last_of_run(last_of_run)
	);

	always #5 clk = ~clk;

	// Accepted requests are noted before records are checked, so a byte and
	// a record taken at the same edge are seen in the right order.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				ledger.sync = cfg_sync;
			if (rx_valid && !rx_stall)
				ledger.take_byte(rx_byte);
			if (res_valid && !res_stall) begin
				ledger.check_record('{msg_id, payload_len, status, has_channel, channel,
					event_code, checksum_received, checksum_expected, last_of_run});
				stall_left <= res_quiet ? 0 : $urandom_range(0, 14);
				res_stall <= !res_quiet && ($urandom_range(0, 1) == 1);
			end else if (stall_left > 1) begin
				stall_left <= stall_left - 1;
			end else begin
				stall_left <= 0;
				res_stall <= 1'b0;
			end
		end
	end

	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = rx_quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (rx_stall);
	endtask

	task automatic send_outgoing();
		while (outgoing.size() > 0)
			send_byte(outgoing.pop_front());
	endtask

	// Returns once every expected record is in and the block has had time to
	// finish bytes that complete nothing.
	task automatic drain();
		rx_valid <= 1'b0;
		while (ledger.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_sync(logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_sync <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_sync = v;
	endtask

	function automatic void add_frame(logic [7:0] id, logic [7:0] len, logic [7:0] p0,
			logic [7:0] p1, bit corrupt);
		logic [7:0] sum, pb;
		int i;
		sum = id ^ len;
		outgoing.push_back(cur_sync);
		outgoing.push_back(id);
		outgoing.push_back(len);
		for (i = 0; i < len; i++) begin
			pb = (i == 0) ? p0 : (i == 1) ? p1 : 8'($urandom);
			sum ^= pb;
			outgoing.push_back(pb);
		end
		if (corrupt)
			sum ^= 8'h01 << $urandom_range(0, 7);
		outgoing.push_back(sum);
	endfunction

	function automatic void add_random_frame(bit corrupt);
		logic [7:0] id, len, want;
		int pick;
		case ($urandom_range(0, 5))
			0: id = ID_FAULT;
			1: id = ID_POWER_GOOD;
			2: id = ID_KILL_SWITCH;
			3: id = ID_CURRENTS;
			default: id = 8'($urandom);
		endcase
		pick = $urandom_range(0, 99);
		if (pick < 45)
			len = (id == ID_FAULT || id == ID_POWER_GOOD) ? LEN_EVENT :
				(id == ID_CURRENTS) ? LEN_CURRENTS :
				(id == ID_KILL_SWITCH) ? LEN_KILL_SWITCH : 8'($urandom_range(0, 4));
		else if (pick < 88)
			len = 8'($urandom_range(0, 8));
		else if (pick < 97)
			len = 8'($urandom_range(9, 40));
		else
			len = 8'($urandom_range(200, 255));
		want = (id == ID_FAULT) ? CODE_FAULT : CODE_POWER_GOOD;
		add_frame(id, len, 8'($urandom), ($urandom_range(0, 3) != 0) ? want : 8'($urandom),
			corrupt);
	endfunction

	task automatic run_random_phase();
		int sent, pick;
		sent = 0;
		while (sent < BYTES_PER_PHASE) begin
			if ($urandom_range(0, 9) == 0) begin
				rx_quiet = ($urandom_range(0, 3) == 0);
				res_quiet = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				add_random_frame(1'b0);
			end else if (pick < 80) begin
				add_random_frame(1'b1);
			end else if (pick < 88) begin
				add_random_frame(1'b0);
				repeat ($urandom_range(1, 3)) void'(outgoing.pop_back());
			end else begin
				repeat ($urandom_range(1, 6))
					outgoing.push_back(($urandom_range(0, 4) == 0) ? cur_sync : 8'($urandom));
				send_outgoing();
				continue;
			end
			sent += outgoing.size();
			send_outgoing();
		end
	endtask

	initial begin
		ledger = new();
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_sync(SYNC_RESET);

		// Noise with no sync byte in it is thrown away once four bytes are held.
		outgoing = '{8'h00, 8'hFF, 8'h55, 8'h01};
		add_frame(ID_FAULT, LEN_EVENT, 8'hFF, CODE_FAULT, 1'b0);
		add_frame(ID_FAULT, LEN_EVENT, 8'h00, 8'h03, 1'b0);
		add_frame(ID_FAULT, 8'd3, 8'h01, CODE_FAULT, 1'b0);
		add_frame(ID_POWER_GOOD, LEN_EVENT, 8'h80, CODE_POWER_GOOD, 1'b0);
		add_frame(ID_POWER_GOOD, LEN_EVENT, 8'h7F, CODE_FAULT, 1'b0);
		add_frame(ID_POWER_GOOD, 8'd0, 8'h00, 8'h00, 1'b0);
		add_frame(ID_KILL_SWITCH, LEN_KILL_SWITCH, 8'h00, 8'h00, 1'b0);
		add_frame(ID_KILL_SWITCH, 8'd1, 8'h00, 8'h00, 1'b0);
		add_frame(ID_CURRENTS, LEN_CURRENTS, 8'h00, 8'h00, 1'b0);
		add_frame(ID_CURRENTS, 8'd31, 8'h00, 8'h00, 1'b0);
		add_frame(8'h00, 8'd0, 8'h00, 8'h00, 1'b0);
		add_frame(ID_KILL_SWITCH, LEN_KILL_SWITCH, 8'h00, 8'h00, 1'b1);
		add_frame(ID_FAULT, LEN_EVENT, 8'h01, CODE_FAULT, 1'b0);
		// A long frame holds back 64 short ones; its last byte completes all of
		// them at once, one more than a single byte may release.
		outgoing.push_back(cur_sync);
		outgoing.push_back(8'h55);
		outgoing.push_back(8'hFF);
		repeat (64) begin
			outgoing.push_back(cur_sync);
			outgoing.push_back(ID_KILL_SWITCH);
			outgoing.push_back(LEN_KILL_SWITCH);
			outgoing.push_back(ID_KILL_SWITCH ^ LEN_KILL_SWITCH);
		end
		add_frame(ID_KILL_SWITCH, LEN_KILL_SWITCH, 8'h00, 8'h00, 1'b0);
		send_outgoing();
		run_random_phase();

		for (phase_sync_pick = 0; phase_sync_pick < 4; phase_sync_pick++) begin
			drain();
			case (phase_sync_pick)
				0: write_sync(8'h00);
				1: write_sync(8'hFF);
				2: write_sync(8'($urandom));
				default: write_sync(SYNC_RESET);
			endcase
			rx_quiet = ($urandom_range(0, 2) == 0);
			res_quiet = ($urandom_range(0, 2) == 0);
			run_random_phase();
		end

		drain();
		if (ledger.failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
